// File: hdl/cbpw_pkg.sv
// Package for the CPU busy percentage window block.
// Holds the sequencer state type, divider status struct and fixed constants.
// No dependencies.
package cbpw_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CNT_W  = $clog2(WORD_W);
  localparam int unsigned PCT_W  = 7;
  localparam int unsigned WLEN_W = 16;

  localparam logic [WORD_W-1:0] US_PER_MS  = 32'd1000;
  localparam logic [WORD_W-1:0] PCT_SCALE  = 32'd100;
  localparam logic [PCT_W-1:0]  PCT_MAX    = 7'd100;
  localparam logic [WLEN_W-1:0] WLEN_RESET = 16'd2000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_START_W,
    S_DIV_W,
    S_SUB,
    S_SCALE,
    S_START_P,
    S_DIV_P,
    S_OUT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: hdl/cbpw_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on cbpw_pkg. A zero divisor yields an all-ones quotient.
module cbpw_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [cbpw_pkg::WORD_W-1:0] dividend,
  input  logic [cbpw_pkg::WORD_W-1:0] divisor,
  output logic [cbpw_pkg::WORD_W-1:0] quotient,
  output cbpw_pkg::div_stat_t         stat
);
  import cbpw_pkg::*;

  logic              active;
  logic              done;
  logic [CNT_W-1:0]  cnt;
  logic [WORD_W-1:0] rem;
  logic [WORD_W-1:0] quo;
  logic [WORD_W-1:0] dvsr;
  logic [WORD_W:0]   sh;
  logic [WORD_W:0]   diff;
  logic              ge;

  assign sh   = {rem, quo[WORD_W-1]};
  assign diff = sh - {1'b0, dvsr};
  assign ge   = sh >= {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (active) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(WORD_W - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= dividend;
      dvsr <= divisor;
    end else if (active) begin
      rem <= ge ? diff[WORD_W-1:0] : sh[WORD_W-1:0];
      quo <= {quo[WORD_W-2:0], ge};
    end
  end

  assign quotient  = quo;
  assign stat.busy = active;
  assign stat.done = done;

  a_start_busy: assert property (@(posedge clk) disable iff (rst) start |=> active)
    else $error("divider did not start");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !active)
    else $error("divider done while active");
  a_done_after: assert property (@(posedge clk) disable iff (rst) done |-> $past(active))
    else $error("divider done without a run");

endmodule

// File: hdl/cpu_busy_percent_window.sv
// CPU busy percentage over a millisecond window, top level.
// Depends on cbpw_pkg and cbpw_div.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one poll item: now_ms, body_ms,
//   sleep_total_ms and wait_total_us. Output channel (out_valid/out_ready)
//   returns exactly one item per poll: busy_pct and window_closed.
//   cfg_we/cfg_data write window_length_ms; write only while idle.
//   A poll that does not close a window goes from S_EVAL to S_OUT, where
//   its result is loaded into the output register. A closing poll runs
//   two passes of the shared bit-serial divider (wait delta by 1000, then
//   scaled busy time by the elapsed time) before it reaches S_OUT.
//   One poll at a time: the next poll is taken once the result is in the
//   output register, so no new poll is taken before the last one is done.
//   Reset clears the window (not started), accumulator, counter bases and
//   last percentage, and sets window_length_ms to 2000.
//   A stalled receiver holds the result in the output register; the block
//   then finishes at most one further item and waits.
module cpu_busy_percent_window (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] now_ms,
  input  logic [31:0] body_ms,
  input  logic [31:0] sleep_total_ms,
  input  logic [31:0] wait_total_us,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  busy_pct,
  output logic        window_closed
);
  import cbpw_pkg::*;

  state_t state, state_next;

  logic [WLEN_W-1:0] window_length_ms;
  logic [WORD_W-1:0] busy_accum;
  logic [WORD_W-1:0] window_start;
  logic [WORD_W-1:0] sleep_base;
  logic [WORD_W-1:0] wait_base;
  logic [PCT_W-1:0]  last_pct;

  logic [WORD_W-1:0] now_r;
  logic [WORD_W-1:0] body_r;
  logic [WORD_W-1:0] sleep_r;
  logic [WORD_W-1:0] wait_r;

  logic [WORD_W-1:0] elapsed;
  logic [WORD_W-1:0] sleep_delta;
  logic [WORD_W-1:0] wait_delta;
  logic [WORD_W-1:0] slept;
  logic [WORD_W-1:0] busy;
  logic [WORD_W-1:0] scaled;
  logic              closed;

  logic [WORD_W-1:0] accum_sum;
  logic [WORD_W-1:0] elapsed_now;
  logic              win_end;
  logic              not_started;

  logic              accept;
  logic              out_load;
  logic              div_start;
  logic              div_sel_pct;
  logic [WORD_W-1:0] div_dividend;
  logic [WORD_W-1:0] div_divisor;
  logic [WORD_W-1:0] div_q;
  div_stat_t         div_stat;

  assign accept      = in_valid && in_ready;
  assign not_started = window_start == '0;
  assign accum_sum   = busy_accum + body_r;
  assign elapsed_now = now_r - window_start;
  assign win_end     = elapsed_now >= {{(WORD_W-WLEN_W){1'b0}}, window_length_ms};

  assign div_dividend = div_sel_pct ? scaled : wait_delta;
  assign div_divisor  = div_sel_pct ? elapsed : US_PER_MS;

  cbpw_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_q),
    .stat     (div_stat)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:    if (in_valid) state_next = S_EVAL;
      S_EVAL: begin
        if (!not_started && win_end) state_next = S_START_W;
        else state_next = S_OUT;
      end
      S_START_W: state_next = S_DIV_W;
      S_DIV_W:   if (div_stat.done) state_next = S_SUB;
      S_SUB:     state_next = S_SCALE;
      S_SCALE:   state_next = S_START_P;
      S_START_P: state_next = S_DIV_P;
      S_DIV_P:   if (div_stat.done) state_next = S_OUT;
      S_OUT:     if (!out_valid || out_ready) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    div_start   = 1'b0;
    div_sel_pct = 1'b0;
    out_load    = 1'b0;
    case (state)
      S_IDLE:    in_ready = 1'b1;
      S_START_W: div_start = 1'b1;
      S_START_P: begin
        div_start   = 1'b1;
        div_sel_pct = 1'b1;
      end
      S_OUT:     out_load = !out_valid || out_ready;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length_ms <= WLEN_RESET;
      busy_accum       <= '0;
      window_start     <= '0;
      sleep_base       <= '0;
      wait_base        <= '0;
      last_pct         <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_we) window_length_ms <= cfg_data;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_EVAL: begin
          if (not_started) begin
            window_start <= now_r;
            sleep_base   <= sleep_r;
            wait_base    <= wait_r;
          end else begin
            busy_accum <= accum_sum;
          end
        end
        S_DIV_P: begin
          if (div_stat.done) begin
            last_pct     <= (div_q > {{(WORD_W-PCT_W){1'b0}}, PCT_MAX}) ?
                            PCT_MAX : div_q[PCT_W-1:0];
            busy_accum   <= '0;
            window_start <= now_r;
            sleep_base   <= sleep_r;
            wait_base    <= wait_r;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      now_r   <= now_ms;
      body_r  <= body_ms;
      sleep_r <= sleep_total_ms;
      wait_r  <= wait_total_us;
    end
    case (state)
      S_EVAL: begin
        closed      <= 1'b0;
        elapsed     <= elapsed_now;
        sleep_delta <= sleep_r - sleep_base;
        wait_delta  <= wait_r - wait_base;
      end
      S_DIV_W: if (div_stat.done) slept <= sleep_delta + div_q;
      S_SUB:   busy <= (busy_accum > slept) ? (busy_accum - slept) : '0;
      S_SCALE: scaled <= busy * PCT_SCALE;
      S_DIV_P: if (div_stat.done) closed <= 1'b1;
      default: ;
    endcase
    if (out_load) begin
      busy_pct      <= last_pct;
      window_closed <= closed;
    end
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst) accept |=> !in_ready)
    else $error("second item taken while one is in flight");
  a_pct_range: assert property (@(posedge clk) disable iff (rst) out_valid |-> busy_pct <= PCT_MAX)
    else $error("busy percentage above limit");
  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
      div_stat.done |-> (state == S_DIV_W || state == S_DIV_P))
    else $error("divider finished outside a divide state");

endmodule

// File: tb/sv/cpu_busy_percent_window_tb.sv
// Self-checking testbench for cpu_busy_percent_window: directed and random polls,
// a busy-percentage predictor and an in-order result checker.
// Depends on cbpw_pkg and the cpu_busy_percent_window RTL.
module cpu_busy_percent_window_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cbpw_pkg::*;

  typedef struct {
    logic [WORD_W-1:0] now_ms;
    logic [WORD_W-1:0] body_ms;
    logic [WORD_W-1:0] sleep_ms;
    logic [WORD_W-1:0] wait_us;
  } poll_t;

  typedef struct {
    logic [PCT_W-1:0] pct;
    logic             closed;
  } pct_result_t;

  class busy_window_checker;
    logic [WORD_W-1:0] win_start;
    logic [WORD_W-1:0] busy_sum;
    logic [WORD_W-1:0] sleep_base;
    logic [WORD_W-1:0] wait_base;
    logic [WLEN_W-1:0] win_len;
    logic [PCT_W-1:0]  last_pct;
    pct_result_t       due_pcts[$];
    int                errors;
    int                seen;

    function new();
      win_len    = WLEN_RESET;
      win_start  = '0;
      busy_sum   = '0;
      sleep_base = '0;
      wait_base  = '0;
      last_pct   = '0;
      errors     = 0;
      seen       = 0;
    endfunction

    function void set_window(logic [WLEN_W-1:0] len);
      win_len = len;
    endfunction

    function int pending();
      return due_pcts.size();
    endfunction

    function void note_poll(poll_t p);
      logic [WORD_W-1:0] elapsed;
      logic [WORD_W-1:0] slept;
      logic [WORD_W-1:0] busy;
      logic [WORD_W-1:0] quot;
      pct_result_t       r;
      r.closed = 1'b0;
      if (win_start == '0) begin
        win_start  = p.now_ms;
        sleep_base = p.sleep_ms;
        wait_base  = p.wait_us;
      end else begin
        busy_sum = busy_sum + p.body_ms;
        elapsed  = p.now_ms - win_start;
        if (elapsed >= win_len) begin
          slept = (p.sleep_ms - sleep_base) + (p.wait_us - wait_base) / US_PER_MS;
          busy  = (busy_sum > slept) ? busy_sum - slept : '0;
          if (elapsed == '0) begin
            quot = '1;
          end else begin
            quot = (busy * PCT_SCALE) / elapsed;
          end
          last_pct   = (quot > PCT_MAX) ? PCT_MAX : quot[PCT_W-1:0];
          busy_sum   = '0;
          win_start  = p.now_ms;
          sleep_base = p.sleep_ms;
          wait_base  = p.wait_us;
          r.closed   = 1'b1;
        end
      end
      r.pct = last_pct;
      due_pcts.push_back(r);
    endfunction

    function void check_result(logic [PCT_W-1:0] pct, logic closed);
      pct_result_t want;
      seen++;
      if (due_pcts.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("result %0d: pct %0d closed %0d with no poll waiting", seen, pct, closed);
        return;
      end
      want = due_pcts.pop_front();
      if (want.pct !== pct || want.closed !== closed) begin
        errors++;
        if (errors <= 10)
          $display("result %0d: expected pct %0d closed %0d, got pct %0d closed %0d",
                   seen, want.pct, want.closed, pct, closed);
      end
    endfunction
  endclass

  localparam int IDLE_LIMIT = 4000;
  localparam int ITEMS_PER_PHASE = 150;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] now_ms;
  logic [31:0] body_ms;
  logic [31:0] sleep_total_ms;
  logic [31:0] wait_total_us;
  logic        out_valid;
  logic        out_ready;
  logic [6:0]  busy_pct;
  logic        window_closed;

  busy_window_checker sb;
  bit                 calm;
  int                 hold_len;
  int                 idle_cycles;
  logic [31:0]        cur_now;
  logic [31:0]        cur_sleep;
  logic [31:0]        cur_wait;

  cpu_busy_percent_window dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .now_ms(now_ms),
    .body_ms(body_ms),
    .sleep_total_ms(sleep_total_ms),
    .wait_total_us(wait_total_us),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .busy_pct(busy_pct),
    .window_closed(window_closed)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_poll(input poll_t p);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    now_ms         <= p.now_ms;
    body_ms        <= p.body_ms;
    sleep_total_ms <= p.sleep_ms;
    wait_total_us  <= p.wait_us;
    do @(posedge clk); while (!in_ready);
    sb.note_poll(p);
  endtask

  task automatic poll(input logic [31:0] t, input logic [31:0] body,
                      input logic [31:0] slp, input logic [31:0] wt);
    poll_t p;
    p.now_ms   = t;
    p.body_ms  = body;
    p.sleep_ms = slp;
    p.wait_us  = wt;
    send_poll(p);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic set_window(input logic [15:0] len);
    drain();
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= len;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_window(len);
  endtask

  task automatic make_random_poll(input logic [15:0] len, output poll_t p);
    int unsigned span;
    int unsigned step;
    if ($urandom_range(0, 9) == 0) begin
      p.now_ms   = $urandom;
      p.body_ms  = $urandom;
      p.sleep_ms = $urandom;
      p.wait_us  = $urandom;
      cur_now    = p.now_ms;
      cur_sleep  = p.sleep_ms;
      cur_wait   = p.wait_us;
    end else begin
      span      = len / 3 + 2;
      step      = $urandom_range(0, span);
      cur_now   = cur_now + step;
      cur_sleep = cur_sleep + $urandom_range(0, step / 2 + 1);
      cur_wait  = cur_wait + $urandom_range(0, 1000 * (step / 2) + 999);
      p.now_ms   = cur_now;
      p.sleep_ms = cur_sleep;
      p.wait_us  = cur_wait;
      p.body_ms  = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, step + 2);
    end
  endtask

  initial begin : receiver
    int n;
    int stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_len > 0) begin
        n = hold_len;
        hold_len = 0;
        out_ready <= 1'b0;
        repeat (n) @(negedge clk);
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(busy_pct, window_closed);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("cpu_busy_percent_window_tb: errors");
        $finish;
      end
    end
  end

  initial begin : stimulus
    poll_t       p;
    logic [15:0] len;
    sb             = new();
    calm           = 1'b0;
    hold_len       = 0;
    idle_cycles    = 0;
    cur_now        = $urandom;
    cur_sleep      = $urandom;
    cur_wait       = $urandom;
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_data       = '0;
    in_valid       = 1'b0;
    now_ms         = '0;
    body_ms        = '0;
    sleep_total_ms = '0;
    wait_total_us  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // latch at time zero, counter wrap, window length at reset value
    poll(32'h0, 32'd7, 32'h0, 32'h0);
    poll(32'h0, '1, '1, '1);
    poll(32'hFFFF_F000, 32'h0, '1, '1);
    poll(32'hFFFF_F100, 32'd900, '1, '1);
    poll(32'h0000_03D0, 32'd1200, 32'd4, 32'd999);
    poll(32'h0000_0B9F, '1, 32'd4, 32'd999);
    poll(32'h0000_0BA0, 32'd2, 32'd1004, 32'd5000);
    // zero length: close on every poll of a started window, zero elapsed, restart at time zero
    set_window(16'h0);
    poll(32'h0000_0BA0, 32'h0, 32'd1004, 32'd5000);
    poll(32'h0, 32'd5, 32'h0, 32'h0);
    poll(32'd123, 32'd5, 32'd7, 32'd8);
    poll(32'd123, 32'h0, 32'd7, 32'd8);
    set_window(16'hFFFF);
    poll(32'd65657, 32'h0200_0000, 32'd7, 32'd8);
    poll(32'd65658, 32'h8000_0000, 32'd9, 32'd2_000_008);
    set_window(16'd1);
    poll(32'd65659, 32'd1, 32'h8000_0000, 32'd8);
    poll(32'd65660, '1, 32'h8000_0000, 32'd8);
    poll(32'd65661, 32'h0, 32'h7FFF_FFFF, '1);

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: len = 16'd1;
        1: len = 16'hFFFF;
        2: len = 16'h0;
        3: len = 16'd2000;
        default: len = $urandom_range(2, 300);
      endcase
      set_window(len);
      calm = (ph == 3);
      if (ph == 5) hold_len = 300;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (ph == 7 && i == ITEMS_PER_PHASE / 2) drain();
        make_random_poll(len, p);
        send_poll(p);
      end
    end

    drain();
    sb.errors += sb.pending();
    if (sb.errors == 0) begin
      $display("cpu_busy_percent_window_tb: clean");
    end else begin
      $display("cpu_busy_percent_window_tb: errors");
    end
    $finish;
  end
endmodule
